// ===== src/sliding_ssd_template_match_assert.svh =====
// ============================================================================
// Assertion macros for the sliding SSD template matcher
// Clocked implication checks that compile to nothing under NO_ASSERTIONS.
// ============================================================================
`ifndef SLIDING_SSD_TEMPLATE_MATCH_ASSERT_SVH
`define SLIDING_SSD_TEMPLATE_MATCH_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SSD_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);
`define SSD_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);
`else
`define SSD_ASSERT_IMP(lbl, ck, rs, ante, cons, msg)
`define SSD_ASSERT_NXT(lbl, ck, rs, ante, cons, msg)
`endif
`endif

// ===== src/ssdtm_pkg.sv =====
// ============================================================================
// ssdtm_pkg
// Shared constants and types of the sliding SSD template matcher.
// ============================================================================
`default_nettype none
package ssdtm_pkg;
  localparam int MAX_ROWS_DEF = 128;
  localparam int MAX_TEMPLATE_COLS_DEF = 64;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int LAG_W = 16;
  localparam int SCORE_W = 30;
  localparam int ROWS_REG_W = 8;
  localparam int COLS_REG_W = 7;
  localparam int CFG_W = 8;
  localparam logic [SCORE_W-1:0] SCORE_MAX = 30'd536870912;

  localparam logic REG_ROWS_IN_USE = 1'b0;
  localparam logic REG_TEMPLATE_COLS = 1'b1;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_SIGNAL = 1'b1;

  typedef struct packed {
    logic is_load;
    logic first;
    logic emit;
  } cmd_flags_t;

  typedef struct packed {
    logic idle;
    logic pipe_busy;
  } bk_status_t;
endpackage
`default_nettype wire

// ===== src/ssdtm_front.sv =====
// ============================================================================
// ssdtm_front
// Accepts words, tracks load/row/column position and builds back-end commands.
// ============================================================================
`default_nettype none
module ssdtm_front #(
  parameter int MAX_ROWS = ssdtm_pkg::MAX_ROWS_DEF,
  parameter int MAX_TEMPLATE_COLS = ssdtm_pkg::MAX_TEMPLATE_COLS_DEF,
  parameter int SAMPLE_BITS = ssdtm_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic accept,
  input  wire logic op,
  input  wire logic last_sample,
  input  wire logic [$clog2(MAX_ROWS+1)-1:0] rows,
  input  wire logic [$clog2(MAX_TEMPLATE_COLS+1)-1:0] cols,
  input  wire logic [$clog2(MAX_ROWS*MAX_TEMPLATE_COLS+1)-1:0] size,
  output ssdtm_pkg::cmd_flags_t flags,
  output logic [((MAX_ROWS*MAX_TEMPLATE_COLS)>1 ? $clog2(MAX_ROWS*MAX_TEMPLATE_COLS) : 1)-1:0]
    load_addr,
  output logic [(MAX_ROWS>1 ? $clog2(MAX_ROWS) : 1)-1:0] row,
  output logic [(MAX_TEMPLATE_COLS>1 ? $clog2(MAX_TEMPLATE_COLS) : 1)-1:0] slot,
  output logic [(MAX_TEMPLATE_COLS>1 ? $clog2(MAX_TEMPLATE_COLS) : 1)-1:0] emit_slot,
  output logic [$clog2(MAX_TEMPLATE_COLS+1)-1:0] open_cnt,
  output logic [ssdtm_pkg::LAG_W-1:0] lag
);
  localparam int DEPTH = MAX_ROWS * MAX_TEMPLATE_COLS;
  localparam int AW = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int RW = MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1;
  localparam int RCW = $clog2(MAX_ROWS + 1);
  localparam int SW = MAX_TEMPLATE_COLS > 1 ? $clog2(MAX_TEMPLATE_COLS) : 1;
  localparam int CCW = $clog2(MAX_TEMPLATE_COLS + 1);
  localparam int SZW = $clog2(DEPTH + 1);
  localparam int LW = ssdtm_pkg::LAG_W;

  logic [AW-1:0] load_position;
  logic [RW-1:0] row_position;
  logic [LW-1:0] signal_column;
  logic [SW-1:0] newest_slot;
  logic [CCW-1:0] cols_started;

  logic [AW-1:0] lp_cur, lp_next;
  logic [SZW-1:0] lp_inc;
  logic [RCW-1:0] row_inc;
  logic end_col, first;
  logic [RW-1:0] r;
  logic [SW-1:0] ns;
  logic [CCW-1:0] cs_next;
  logic [SW:0] es_tmp;

  always_comb begin
    lp_cur = (SZW'(load_position) >= size) ? '0 : load_position;
    lp_inc = SZW'(lp_cur) + SZW'(1);
    lp_next = (lp_inc >= size) ? '0 : AW'(lp_inc);

    row_inc = RCW'(row_position) + RCW'(1);
    end_col = row_inc >= rows;
    r = (RCW'(row_position) >= rows) ? RW'(rows - RCW'(1)) : row_position;
    first = (r == '0);

    if (first) begin
      ns = ((SW+1)'(newest_slot) + (SW+1)'(1) == (SW+1)'(MAX_TEMPLATE_COLS)) ? '0 :
           SW'(newest_slot + SW'(1));
    end else begin
      ns = newest_slot;
    end
    cs_next = (first && cols_started < CCW'(MAX_TEMPLATE_COLS)) ?
              CCW'(cols_started + CCW'(1)) : cols_started;
    open_cnt = (cs_next < cols) ? cs_next : cols;

    es_tmp = (SW+1)'(ns) + (SW+1)'(MAX_TEMPLATE_COLS) - (SW+1)'(cols - CCW'(1));
    if (es_tmp >= (SW+1)'(MAX_TEMPLATE_COLS)) begin
      es_tmp = es_tmp - (SW+1)'(MAX_TEMPLATE_COLS);
    end
    emit_slot = SW'(es_tmp);

    flags.is_load = (op == ssdtm_pkg::OP_LOAD);
    flags.first = first;
    flags.emit = end_col && (cs_next >= cols);
    load_addr = lp_cur;
    row = r;
    slot = ns;
    lag = signal_column - LW'(cols - CCW'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_position <= '0;
      row_position <= '0;
      signal_column <= '0;
      newest_slot <= '0;
      cols_started <= '0;
    end else if (accept) begin
      if (op == ssdtm_pkg::OP_LOAD) begin
        load_position <= lp_next;
      end else if (last_sample) begin
        row_position <= '0;
        signal_column <= '0;
        newest_slot <= '0;
        cols_started <= '0;
      end else begin
        newest_slot <= ns;
        cols_started <= cs_next;
        if (end_col) begin
          row_position <= '0;
          signal_column <= signal_column + LW'(1);
        end else begin
          row_position <= RW'(r + RW'(1));
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== src/ssdtm_queue.sv =====
// ============================================================================
// ssdtm_queue
// Small command FIFO between front and back end.
// ============================================================================
`default_nettype none
module ssdtm_queue #(
  parameter int WIDTH = 8
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic pop,
  output logic [WIDTH-1:0] rdata,
  output logic full,
  output logic empty
);
  localparam int DEPTH = 4;
  localparam int PW = 2;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0] wptr, rptr;
  logic [PW:0] count;

  assign full = (count == (PW+1)'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + PW'(1);
      end
      if (pop) begin
        rptr <= rptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + (PW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (PW+1)'(1);
      end
    end
  end
endmodule
`default_nettype wire

// ===== src/ssdtm_back.sv =====
// ============================================================================
// ssdtm_back
// Template store, window-sum RAM update pipeline, serial divider, output reg.
// ============================================================================
`default_nettype none
module ssdtm_back #(
  parameter int MAX_ROWS = ssdtm_pkg::MAX_ROWS_DEF,
  parameter int MAX_TEMPLATE_COLS = ssdtm_pkg::MAX_TEMPLATE_COLS_DEF,
  parameter int SAMPLE_BITS = ssdtm_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic q_empty,
  output logic q_pop,
  input  wire ssdtm_pkg::cmd_flags_t c_flags,
  input  wire logic [SAMPLE_BITS-1:0] c_value,
  input  wire logic [((MAX_ROWS*MAX_TEMPLATE_COLS)>1 ? $clog2(MAX_ROWS*MAX_TEMPLATE_COLS) : 1)-1:0]
    c_addr,
  input  wire logic [(MAX_ROWS>1 ? $clog2(MAX_ROWS) : 1)-1:0] c_row,
  input  wire logic [(MAX_TEMPLATE_COLS>1 ? $clog2(MAX_TEMPLATE_COLS) : 1)-1:0] c_slot,
  input  wire logic [(MAX_TEMPLATE_COLS>1 ? $clog2(MAX_TEMPLATE_COLS) : 1)-1:0] c_emit_slot,
  input  wire logic [$clog2(MAX_TEMPLATE_COLS+1)-1:0] c_open,
  input  wire logic [ssdtm_pkg::LAG_W-1:0] c_lag,
  input  wire logic [$clog2(MAX_ROWS+1)-1:0] rows,
  input  wire logic [$clog2(MAX_ROWS*MAX_TEMPLATE_COLS+1)-1:0] size,
  output logic out_valid,
  input  wire logic out_ready,
  output logic [ssdtm_pkg::LAG_W-1:0] out_lag,
  output logic [ssdtm_pkg::SCORE_W-1:0] out_score,
  output logic out_zero,
  output ssdtm_pkg::bk_status_t status
);
  localparam int DEPTH = MAX_ROWS * MAX_TEMPLATE_COLS;
  localparam int AW = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int SW = MAX_TEMPLATE_COLS > 1 ? $clog2(MAX_TEMPLATE_COLS) : 1;
  localparam int CCW = $clog2(MAX_TEMPLATE_COLS + 1);
  localparam int SZW = $clog2(DEPTH + 1);
  localparam int DW = SAMPLE_BITS + 1;
  localparam int SQW = 2 * DW;
  localparam int SUM_W = SQW + SZW;
  localparam int NUM_W = SZW + 16;
  localparam int BCW = $clog2(NUM_W + 1);
  localparam int LW = ssdtm_pkg::LAG_W;
  localparam int QW = ssdtm_pkg::SCORE_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RUN = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_ERD = 3'd3;
  localparam logic [2:0] ST_EWAIT = 3'd4;
  localparam logic [2:0] ST_DIV = 3'd5;
  localparam logic [2:0] ST_OUT = 3'd6;

  logic [SAMPLE_BITS-1:0] tmem [DEPTH];
  logic [SUM_W-1:0] wmem [MAX_TEMPLATE_COLS];

  logic [2:0] state;
  logic [SAMPLE_BITS-1:0] x;
  logic first, emit;
  logic [SW-1:0] eslot;
  logic [LW-1:0] lag;
  logic [CCW-1:0] open_cnt, kcnt;
  logic [AW-1:0] taddr;
  logic [SW-1:0] wslot;

  logic t_we;
  logic [SW-1:0] w_raddr;
  logic [SAMPLE_BITS-1:0] trd;
  logic [SUM_W-1:0] wrd;

  logic p1, p2, p3;
  logic p1_first, p2_first, p3_first;
  logic [SW-1:0] p1_slot, p2_slot, p3_slot;
  logic [SUM_W-1:0] p2_sum, p3_sum;
  logic signed [DW-1:0] p2_d;
  logic [SQW-1:0] p3_sq;
  logic signed [DW-1:0] d_next;
  logic signed [SQW-1:0] sq_next;

  logic [NUM_W-1:0] num, quo;
  logic [SUM_W-1:0] rem, div;
  logic [SUM_W:0] rem_s;
  logic ge;
  logic [BCW-1:0] bcnt;
  logic zero;

  logic issue;
  assign issue = (state == ST_RUN);
  assign t_we = (state == ST_IDLE) && !q_empty && c_flags.is_load;
  assign q_pop = (state == ST_IDLE) && !q_empty;
  assign w_raddr = (state == ST_ERD) ? eslot : wslot;
  assign status.idle = (state == ST_IDLE);
  assign status.pipe_busy = p1 || p2 || p3;

  always_ff @(posedge clk) begin
    if (t_we) begin
      tmem[c_addr] <= c_value;
    end
    trd <= tmem[taddr];
  end

  always_ff @(posedge clk) begin
    if (p3) begin
      wmem[p3_slot] <= p3_first ? p3_sq : p3_sum + SUM_W'(p3_sq);
    end
    wrd <= wmem[w_raddr];
  end

  always_comb begin
    d_next = $signed({x[SAMPLE_BITS-1], x}) - $signed({trd[SAMPLE_BITS-1], trd});
    sq_next = p2_d * p2_d;
    rem_s = {rem, num[NUM_W-1]};
    ge = rem_s >= {1'b0, div};
  end

  always_ff @(posedge clk) begin
    p1_first <= issue && first && (kcnt == '0);
    p1_slot <= wslot;
    p2_first <= p1_first;
    p2_slot <= p1_slot;
    p2_sum <= wrd;
    p2_d <= d_next;
    p3_first <= p2_first;
    p3_slot <= p2_slot;
    p3_sum <= p2_sum;
    p3_sq <= $unsigned(sq_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1 <= 1'b0;
      p2 <= 1'b0;
      p3 <= 1'b0;
    end else begin
      p1 <= issue;
      p2 <= p1;
      p3 <= p2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != ST_OUT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (!q_empty && !c_flags.is_load) begin
            x <= c_value;
            first <= c_flags.first;
            emit <= c_flags.emit;
            eslot <= c_emit_slot;
            lag <= c_lag;
            open_cnt <= c_open;
            kcnt <= '0;
            taddr <= AW'(c_row);
            wslot <= c_slot;
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          kcnt <= kcnt + CCW'(1);
          taddr <= AW'(SZW'(taddr) + SZW'(rows));
          wslot <= (wslot == '0) ? SW'(MAX_TEMPLATE_COLS - 1) : SW'(wslot - SW'(1));
          if (kcnt + CCW'(1) >= open_cnt) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!p1 && !p2 && !p3) begin
            state <= emit ? ST_ERD : ST_IDLE;
          end
        end
        ST_ERD: begin
          state <= ST_EWAIT;
        end
        ST_EWAIT: begin
          div <= wrd;
          zero <= (wrd == '0);
          rem <= '0;
          num <= {size, 16'd0};
          quo <= '0;
          bcnt <= '0;
          state <= (wrd == '0) ? ST_OUT : ST_DIV;
        end
        ST_DIV: begin
          rem <= ge ? SUM_W'(rem_s - {1'b0, div}) : SUM_W'(rem_s);
          num <= num << 1;
          quo <= (quo << 1) | NUM_W'(ge);
          bcnt <= bcnt + BCW'(1);
          if (bcnt == BCW'(NUM_W - 1)) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_lag <= lag;
            out_zero <= zero;
            if (zero || 64'(quo) > 64'(ssdtm_pkg::SCORE_MAX)) begin
              out_score <= ssdtm_pkg::SCORE_MAX;
            end else begin
              out_score <= QW'(quo);
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== src/sliding_ssd_template_match.sv =====
// ============================================================================
// sliding_ssd_template_match
// SSD template matching over a streamed column-major signal, Q14.16 score out.
// ============================================================================
//  channel   dir  payload
//  s_*       in   tdata: sample_value; tuser: op; tlast: last_sample
//  m_*       out  tdata: lag_index, score; tuser: zero_distance
//  cfg_*     in   index 0 rows_in_use, index 1 template_cols
//
//  Template word: written to the template store by the back end from ST_IDLE.
//  Signal word: one update per open window through the p1/p2/p3 pipeline; one window-sum RAM access per cycle.
//  Completed window adds a bit-serial divider pass (30 steps) plus m_tready wait.
//  Four-entry command queue lets s_* accept while the back end works.
//  m_tvalid holds its word while m_tready is low; rst is synchronous.
`default_nettype none
`include "sliding_ssd_template_match_assert.svh"
module sliding_ssd_template_match #(
  parameter int MAX_ROWS = ssdtm_pkg::MAX_ROWS_DEF,
  parameter int MAX_TEMPLATE_COLS = ssdtm_pkg::MAX_TEMPLATE_COLS_DEF,
  parameter int SAMPLE_BITS = ssdtm_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic s_tready,
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0] s_tdata,  // sample_value
  input  wire logic s_tuser,                              // op
  input  wire logic s_tlast,
  output logic m_tvalid,
  input  wire logic m_tready,
  output logic [47:0] m_tdata,                            // lag_index, score
  output logic m_tuser,                                   // zero_distance
  input  wire logic cfg_we,
  input  wire logic cfg_addr,
  input  wire logic [ssdtm_pkg::CFG_W-1:0] cfg_data
);
  localparam int DEPTH = MAX_ROWS * MAX_TEMPLATE_COLS;
  localparam int AW = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int RW = MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1;
  localparam int RCW = $clog2(MAX_ROWS + 1);
  localparam int SW = MAX_TEMPLATE_COLS > 1 ? $clog2(MAX_TEMPLATE_COLS) : 1;
  localparam int CCW = $clog2(MAX_TEMPLATE_COLS + 1);
  localparam int SZW = $clog2(DEPTH + 1);
  localparam int LW = ssdtm_pkg::LAG_W;
  localparam int CMD_W = 3 + SAMPLE_BITS + AW + RW + SW + SW + CCW + LW;

  logic [ssdtm_pkg::ROWS_REG_W-1:0] rows_in_use;
  logic [ssdtm_pkg::COLS_REG_W-1:0] template_cols;
  logic [RCW-1:0] rows;
  logic [CCW-1:0] cols;
  logic [SZW-1:0] size;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= 8'd128;
      template_cols <= 7'd64;
    end else if (cfg_we) begin
      case (cfg_addr)
        ssdtm_pkg::REG_ROWS_IN_USE: rows_in_use <= cfg_data;
        ssdtm_pkg::REG_TEMPLATE_COLS: template_cols <= cfg_data[ssdtm_pkg::COLS_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (rows_in_use == '0) begin
      rows = RCW'(1);
    end else if (32'(rows_in_use) > MAX_ROWS) begin
      rows = RCW'(MAX_ROWS);
    end else begin
      rows = RCW'(rows_in_use);
    end
    if (template_cols == '0) begin
      cols = CCW'(1);
    end else if (32'(template_cols) > MAX_TEMPLATE_COLS) begin
      cols = CCW'(MAX_TEMPLATE_COLS);
    end else begin
      cols = CCW'(template_cols);
    end
    size = SZW'(32'(rows) * 32'(cols));
  end

  logic accept, q_full, q_empty, q_pop;
  ssdtm_pkg::cmd_flags_t f_flags, b_flags;
  logic [AW-1:0] f_addr, b_addr;
  logic [RW-1:0] f_row, b_row;
  logic [SW-1:0] f_slot, b_slot, f_eslot, b_eslot;
  logic [CCW-1:0] f_open, b_open;
  logic [LW-1:0] f_lag, b_lag;
  logic [SAMPLE_BITS-1:0] b_value;
  logic [CMD_W-1:0] q_wdata, q_rdata;
  logic [LW-1:0] out_lag;
  logic [ssdtm_pkg::SCORE_W-1:0] out_score;
  ssdtm_pkg::bk_status_t status;

  assign s_tready = !q_full;
  assign accept = s_tvalid && !q_full;

  ssdtm_front #(
    .MAX_ROWS(MAX_ROWS), .MAX_TEMPLATE_COLS(MAX_TEMPLATE_COLS), .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk(clk), .rst(rst), .accept(accept), .op(s_tuser), .last_sample(s_tlast),
    .rows(rows), .cols(cols), .size(size), .flags(f_flags), .load_addr(f_addr),
    .row(f_row), .slot(f_slot), .emit_slot(f_eslot), .open_cnt(f_open), .lag(f_lag)
  );

  assign q_wdata = {f_flags, s_tdata[SAMPLE_BITS-1:0], f_addr, f_row, f_slot, f_eslot,
                    f_open, f_lag};

  ssdtm_queue #(.WIDTH(CMD_W)) u_queue (
    .clk(clk), .rst(rst), .push(accept), .wdata(q_wdata), .pop(q_pop),
    .rdata(q_rdata), .full(q_full), .empty(q_empty)
  );

  assign {b_flags, b_value, b_addr, b_row, b_slot, b_eslot, b_open, b_lag} = q_rdata;

  ssdtm_back #(
    .MAX_ROWS(MAX_ROWS), .MAX_TEMPLATE_COLS(MAX_TEMPLATE_COLS), .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk(clk), .rst(rst), .q_empty(q_empty), .q_pop(q_pop), .c_flags(b_flags),
    .c_value(b_value), .c_addr(b_addr), .c_row(b_row), .c_slot(b_slot),
    .c_emit_slot(b_eslot), .c_open(b_open), .c_lag(b_lag), .rows(rows), .size(size),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_lag(out_lag), .out_score(out_score),
    .out_zero(m_tuser), .status(status)
  );

  assign m_tdata = {2'b00, out_score, out_lag};

  `SSD_ASSERT_IMP(a_zero_sat, clk, rst, m_tvalid && m_tuser, out_score == ssdtm_pkg::SCORE_MAX, "zero distance without saturated score")
  `SSD_ASSERT_IMP(a_score_max, clk, rst, m_tvalid, out_score <= ssdtm_pkg::SCORE_MAX, "score above maximum")
  `SSD_ASSERT_IMP(a_idle_pipe, clk, rst, status.idle, !status.pipe_busy, "update pipe busy while idle")
  `SSD_ASSERT_NXT(a_start_pipe, clk, rst, status.idle && !q_empty, !status.pipe_busy, "pipe busy right after dispatch")
endmodule
`default_nettype wire
